// ----- rtl/klifo_pkg.sv -----
`default_nettype none

package klifo_pkg;

    // Field widths
    localparam int OP_W       = 3;
    localparam int KEY_W      = 32;
    localparam int DATA_W     = 32;
    localparam int ST_W       = 3;
    localparam int CNT_OUT_W  = 5;

    // Packed beat widths, rounded up to whole bytes
    localparam int IN_TDATA_W  = 72;
    localparam int OUT_TDATA_W = 80;

    // Default number of cells in the chain
    localparam int DEF_STACK_DEPTH = 16;

    // Operation codes
    typedef enum logic [OP_W-1:0] {
        OP_PUSH   = 3'd0,
        OP_POP    = 3'd1,
        OP_PEEK   = 3'd2,
        OP_CHANGE = 3'd3,
        OP_CLEAR  = 3'd4
    } t_op;

    // Result status codes
    typedef enum logic [ST_W-1:0] {
        ST_OK      = 3'd0,
        ST_DUP     = 3'd1,
        ST_UNDER   = 3'd2,
        ST_MISSING = 3'd3,
        ST_OVER    = 3'd4
    } t_status;

    // Command broadcast to every cell of the chain
    typedef struct packed {
        logic              push;    // shift toward the bottom, cell 0 loads new entry
        logic              pop;     // shift toward the top
        logic              change;  // matching cell rewrites its data
        logic [KEY_W-1:0]  key;
        logic [DATA_W-1:0] data;
    } t_cell_cmd;

endpackage

`default_nettype wire

// ----- rtl/klifo_cell.sv -----
`default_nettype none

// One stack slot: holds a key/data pair, compares its key against the
// broadcast key, and moves its contents to a neighbor on push or pop.
module klifo_cell (
    input  wire logic                         i_clk,
    input  wire klifo_pkg::t_cell_cmd         i_cmd,
    input  wire logic [klifo_pkg::KEY_W-1:0]  i_key,        // lookup key, straight from the beat
    input  wire logic                         i_occupied,
    input  wire logic [klifo_pkg::KEY_W-1:0]  i_prev_key,   // from the cell nearer the top
    input  wire logic [klifo_pkg::DATA_W-1:0] i_prev_data,
    input  wire logic [klifo_pkg::KEY_W-1:0]  i_next_key,   // from the cell nearer the bottom
    input  wire logic [klifo_pkg::DATA_W-1:0] i_next_data,
    output logic      [klifo_pkg::KEY_W-1:0]  o_key,
    output logic      [klifo_pkg::DATA_W-1:0] o_data,
    output logic                              o_hit
);

    logic [klifo_pkg::KEY_W-1:0]  r_key;
    logic [klifo_pkg::DATA_W-1:0] r_data;
    logic [klifo_pkg::KEY_W-1:0]  n_key;
    logic [klifo_pkg::DATA_W-1:0] n_data;

    // Key match, only for a slot below the fill level
    assign o_hit  = i_occupied && (r_key == i_key);
    assign o_key  = r_key;
    assign o_data = r_data;

    // Shift or rewrite
    always_comb begin
        n_key  = r_key;
        n_data = r_data;
        if (i_cmd.push) begin
            n_key  = i_prev_key;
            n_data = i_prev_data;
        end else if (i_cmd.pop) begin
            n_key  = i_next_key;
            n_data = i_next_data;
        end else if (i_cmd.change && o_hit) begin
            n_data = i_cmd.data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key  <= n_key;
        r_data <= n_data;
    end

endmodule

`default_nettype wire

// ----- rtl/keyed_lifo_stack_core.sv -----
`default_nettype none

// Keyed LIFO stack of STACK_DEPTH key/data entries with unique keys, built as
// a chain of cells with the top of stack in cell 0. Push shifts the chain one
// cell down, pop one cell up; peek and change compare the key in every cell at
// once. Each input beat (operation, key, data) yields exactly one output beat
// (status, key, data, count, empty flag). Throughput is one item per clock:
// the compare, the chain update and the result all complete in the cycle the
// beat is accepted, and the result lands in an output register. The input
// stalls only while that register holds a beat the sink has not taken.
// Reset empties the stack; there is no clearing pass.
module keyed_lifo_stack_core #(
    parameter int STACK_DEPTH = klifo_pkg::DEF_STACK_DEPTH
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // Input: [2:0] operation, [34:3] item_key, [66:35] item_data, [71:67] zero
    input  wire logic                              i_s_tvalid,
    output logic                                   o_s_tready,
    input  wire logic [klifo_pkg::IN_TDATA_W-1:0]  i_s_tdata,
    // Output: [2:0] status, [34:3] result_key, [66:35] result_data,
    //         [71:67] entry_count, [72] stack_empty, [79:73] zero
    output logic                                   o_m_tvalid,
    input  wire logic                              i_m_tready,
    output logic      [klifo_pkg::OUT_TDATA_W-1:0] o_m_tdata
);

    localparam int CNT_W = $clog2(STACK_DEPTH + 1);
    localparam int KW    = klifo_pkg::KEY_W;
    localparam int DW    = klifo_pkg::DATA_W;
    localparam int OUT_USED_W = klifo_pkg::ST_W + KW + DW + klifo_pkg::CNT_OUT_W + 1;

    logic [CNT_W-1:0]                  r_count;
    logic [CNT_W-1:0]                  n_count;
    logic                              r_out_valid;
    logic [klifo_pkg::OUT_TDATA_W-1:0] r_out_tdata;

    logic                      w_accept;
    logic [klifo_pkg::OP_W-1:0] w_op;
    logic [KW-1:0]             w_key;
    logic [DW-1:0]             w_data;
    logic                      w_full;
    logic                      w_empty;
    logic                      w_any_hit;
    logic [DW-1:0]             w_found_data;
    logic [STACK_DEPTH-1:0]    w_hit;
    logic [KW-1:0]             w_cell_key  [STACK_DEPTH];
    logic [DW-1:0]             w_cell_data [STACK_DEPTH];
    klifo_pkg::t_cell_cmd      w_cmd;

    logic [klifo_pkg::ST_W-1:0] w_status;
    logic [KW-1:0]             w_rkey;
    logic [DW-1:0]             w_rdata;

    // Input beat fields
    assign w_op   = i_s_tdata[2:0];
    assign w_key  = i_s_tdata[34:3];
    assign w_data = i_s_tdata[66:35];

    assign o_s_tready = !r_out_valid || i_m_tready;
    assign w_accept   = i_s_tvalid && o_s_tready;

    assign w_full  = (r_count == CNT_W'(STACK_DEPTH));
    assign w_empty = (r_count == '0);

    // Cell chain
    for (genvar g_i = 0; g_i < STACK_DEPTH; g_i++) begin : g_cell
        logic [KW-1:0] w_prev_key;
        logic [DW-1:0] w_prev_data;
        logic [KW-1:0] w_next_key;
        logic [DW-1:0] w_next_data;

        if (g_i == 0) begin : g_top
            assign w_prev_key  = w_cmd.key;
            assign w_prev_data = w_cmd.data;
        end else begin : g_mid
            assign w_prev_key  = w_cell_key[g_i-1];
            assign w_prev_data = w_cell_data[g_i-1];
        end

        if (g_i == STACK_DEPTH - 1) begin : g_bot
            assign w_next_key  = w_cell_key[g_i];
            assign w_next_data = w_cell_data[g_i];
        end else begin : g_up
            assign w_next_key  = w_cell_key[g_i+1];
            assign w_next_data = w_cell_data[g_i+1];
        end

        klifo_cell u_cell (
            .i_clk       (i_clk),
            .i_cmd       (w_cmd),
            .i_key       (w_key),
            .i_occupied  (CNT_W'(g_i) < r_count),
            .i_prev_key  (w_prev_key),
            .i_prev_data (w_prev_data),
            .i_next_key  (w_next_key),
            .i_next_data (w_next_data),
            .o_key       (w_cell_key[g_i]),
            .o_data      (w_cell_data[g_i]),
            .o_hit       (w_hit[g_i])
        );
    end

    // Keys are unique, so at most one cell hits: OR of the masked data
    always_comb begin
        w_found_data = '0;
        for (int i = 0; i < STACK_DEPTH; i++) begin
            w_found_data = w_found_data | (w_hit[i] ? w_cell_data[i] : '0);
        end
    end
    assign w_any_hit = |w_hit;

    // Chain command
    always_comb begin
        w_cmd.push   = w_accept && (w_op == klifo_pkg::OP_PUSH) && !w_any_hit && !w_full;
        w_cmd.pop    = w_accept && (w_op == klifo_pkg::OP_POP) && !w_empty;
        w_cmd.change = w_accept && (w_op == klifo_pkg::OP_CHANGE);
        w_cmd.key    = w_key;
        w_cmd.data   = w_data;
    end

    // Operation decode: status, returned fields, next count
    always_comb begin
        w_status = klifo_pkg::ST_OK;
        w_rkey   = '0;
        w_rdata  = '0;
        n_count  = r_count;
        unique case (w_op)
            klifo_pkg::OP_PUSH: begin
                if (w_any_hit) begin
                    w_status = klifo_pkg::ST_DUP;
                end else if (w_full) begin
                    w_status = klifo_pkg::ST_OVER;
                end else begin
                    n_count = r_count + 1'b1;
                end
            end
            klifo_pkg::OP_POP: begin
                if (w_empty) begin
                    w_status = klifo_pkg::ST_UNDER;
                end else begin
                    w_rkey  = w_cell_key[0];
                    w_rdata = w_cell_data[0];
                    n_count = r_count - 1'b1;
                end
            end
            klifo_pkg::OP_PEEK: begin
                if (w_any_hit) begin
                    w_rdata = w_found_data;
                end else begin
                    w_status = klifo_pkg::ST_MISSING;
                end
            end
            klifo_pkg::OP_CHANGE: begin
                if (!w_any_hit) begin
                    w_status = klifo_pkg::ST_MISSING;
                end
            end
            klifo_pkg::OP_CLEAR: begin
                n_count = '0;
            end
            default: begin
            end
        endcase
    end

    // Fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (w_accept) begin
            r_count <= n_count;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out_tdata <= {(klifo_pkg::OUT_TDATA_W - OUT_USED_W)'(0),
                            (n_count == '0),
                            klifo_pkg::CNT_OUT_W'(n_count),
                            w_rdata, w_rkey, w_status};
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_tdata;

    // Checks
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(STACK_DEPTH))
        else $error("fill level above stack depth");

    a_unique_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_hit))
        else $error("key held in more than one cell");

    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.push |=> r_count == $past(r_count) + 1'b1)
        else $error("successful push did not grow the stack");

    a_empty_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_tdata[72] == (r_out_tdata[71:67] == '0)))
        else $error("empty flag disagrees with count");

endmodule

`default_nettype wire
